/* rtl/assert_macros.svh */
// Assertion macros shared by the line offset lookup RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset
`define LOLU_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Same-cycle implication outside reset
`define LOLU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/lolu_pkg.sv */
// Shared types and constants for the line offset lookup unit.
// No dependencies.
package lolu_pkg;

  // Request kinds carried on the input tuser
  localparam int TUSER_W = 2;

  typedef enum logic [TUSER_W-1:0] {
    REQ_CLEAR = 2'd0,
    REQ_BYTE  = 2'd1,
    REQ_QUERY = 2'd2
  } req_type_t;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

endpackage

/* rtl/lolu_line_ram.sv */
// Line-start table storage: one write port, one registered read port.
// Entry 0 always reads as zero, so it never needs writing. No dependencies.
module lolu_line_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 20,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q_r;
  logic             rd_zero_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r    <= mem[rd_addr];
      rd_zero_r <= (rd_addr == '0);
    end
  end

  // first line always starts at offset zero
  assign rd_data = rd_zero_r ? '0 : rd_q_r;

endmodule

/* rtl/line_offset_index_lookup_unit.sv */
// Line offset lookup unit: top level, ingest, binary search sequencer, result register.
// Depends on lolu_pkg, lolu_line_ram and assert_macros.svh.
//
// A clear beat starts a new text; each text byte beat counts one byte and a newline
// stores the offset of the next byte as a line start in a table RAM with one write
// and one read port (MAX_LINES entries). Clear and byte beats are taken one per cycle
// while no query is in flight. A query beat clamps its offset to the byte count and
// binary-searches the table; each search step is a RAM read (ST_ISSUE), then a
// compare (ST_CMP), and a query holds the input until its result is written to the
// result register, which includes any wait for that register to drain. Byte and
// clear beats are taken while a finished result waits on the output. Newlines beyond
// MAX_LINES set a sticky overflow flag reported with every result.
`include "assert_macros.svh"

module line_offset_index_lookup_unit #(
  parameter int MAX_LINES   = 4096,
  parameter int OFFSET_BITS = 20,
  localparam int LNW     = $clog2(MAX_LINES) + 1,
  localparam int CW      = OFFSET_BITS + 1,
  localparam int IW      = ((8 + OFFSET_BITS + 7) / 8) * 8,
  localparam int OW_RAW  = LNW + CW + OFFSET_BITS + 1,
  localparam int OW      = ((OW_RAW + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [IW-1:0]                in_tdata,  // text_byte, query_offset
  input  logic [lolu_pkg::TUSER_W-1:0] in_tuser,  // req_type
  // result channel
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [OW-1:0]                out_tdata  // line_number, column_number,
                                                  // clamped_offset, table_overflow
);

  import lolu_pkg::*;

  localparam int OB  = OFFSET_BITS;
  localparam int LCW = $clog2(MAX_LINES + 1);
  localparam int AW  = $clog2(MAX_LINES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_CMP
  } state_t;

  state_t          state_r, state_nxt;
  logic [LCW-1:0]  lcount_r, lcount_nxt;
  logic [OB-1:0]   byte_cnt_r, byte_cnt_nxt;
  logic            ovf_r, ovf_nxt;
  logic [LCW-1:0]  lo_r, lo_nxt;
  logic [LCW-1:0]  hi_r, hi_nxt;
  logic [LCW-1:0]  mid_r, mid_nxt;
  logic [OB-1:0]   pos_r, pos_nxt;
  logic [OB-1:0]   start_r, start_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [LNW-1:0]  out_line_r, out_line_nxt;
  logic [CW-1:0]   out_col_r, out_col_nxt;
  logic [OB-1:0]   out_pos_r, out_pos_nxt;
  logic            out_ovf_r, out_ovf_nxt;

  logic            in_fire;
  req_type_t       req;
  logic [7:0]      text_byte;
  logic [OB-1:0]   query_offset;
  logic [LCW:0]    sum;
  logic [LCW-1:0]  mid;
  logic [LCW-1:0]  line_val;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [OB-1:0]   wr_data;
  logic            rd_en;
  logic [OB-1:0]   rd_data;

  // beat unpacking
  assign in_tready    = (state_r == ST_IDLE);
  assign in_fire      = in_tvalid && in_tready;
  assign req          = req_type_t'(in_tuser);
  assign text_byte    = in_tdata[7:0];
  assign query_offset = in_tdata[8 +: OB];

  // search midpoint, floor((lo+hi)/2)
  assign sum      = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid      = sum[LCW:1];
  assign line_val = (lo_r == '0) ? LCW'(1) : lo_r;

  lolu_line_ram #(
    .DEPTH (MAX_LINES),
    .WIDTH (OB)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (mid[AW-1:0]),
    .rd_data (rd_data)
  );

  // next-state logic
  always_comb begin
    state_nxt     = state_r;
    lcount_nxt    = lcount_r;
    byte_cnt_nxt  = byte_cnt_r;
    ovf_nxt       = ovf_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    pos_nxt       = pos_r;
    start_nxt     = start_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_line_nxt  = out_line_r;
    out_col_nxt   = out_col_r;
    out_pos_nxt   = out_pos_r;
    out_ovf_nxt   = out_ovf_r;
    wr_en         = 1'b0;
    wr_addr       = lcount_r[AW-1:0];
    wr_data       = byte_cnt_r + 1'b1;
    rd_en         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (req)
            REQ_CLEAR: begin
              lcount_nxt   = LCW'(1);
              byte_cnt_nxt = '0;
              ovf_nxt      = 1'b0;
            end
            REQ_BYTE: begin
              // bytes past the largest offset are dropped altogether
              if (byte_cnt_r != '1) begin
                byte_cnt_nxt = byte_cnt_r + 1'b1;
                if (text_byte == NEWLINE_BYTE) begin
                  if (lcount_r < LCW'(MAX_LINES)) begin
                    wr_en      = 1'b1;
                    lcount_nxt = lcount_r + 1'b1;
                  end else begin
                    ovf_nxt = 1'b1;
                  end
                end
              end
            end
            REQ_QUERY: begin
              pos_nxt   = (query_offset > byte_cnt_r) ? byte_cnt_r : query_offset;
              lo_nxt    = '0;
              hi_nxt    = lcount_r;
              start_nxt = '0;
              state_nxt = ST_ISSUE;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ISSUE: begin
        if (lo_r < hi_r) begin
          rd_en     = 1'b1;
          mid_nxt   = mid;
          state_nxt = ST_CMP;
        end else if (!out_valid_r || out_tready) begin
          // search done: lo counts the line starts not above pos
          out_valid_nxt = 1'b1;
          out_line_nxt  = LNW'(line_val);
          out_col_nxt   = {1'b0, pos_r} - {1'b0, start_r} + CW'(1);
          out_pos_nxt   = pos_r;
          out_ovf_nxt   = ovf_r;
          state_nxt     = ST_IDLE;
        end
      end
      ST_CMP: begin
        // the last start found not above pos is the start of the answer line
        if (rd_data <= pos_r) begin
          lo_nxt    = mid_r + 1'b1;
          start_nxt = rd_data;
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = ST_ISSUE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lcount_r    <= LCW'(1);
      byte_cnt_r  <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lcount_r    <= lcount_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      mid_r       <= mid_nxt;
      pos_r       <= pos_nxt;
      start_r     <= start_nxt;
      out_line_r  <= out_line_nxt;
      out_col_r   <= out_col_nxt;
      out_pos_r   <= out_pos_nxt;
      out_ovf_r   <= out_ovf_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OW'({out_ovf_r, out_pos_r, out_col_r, out_line_r});

  // checks
  `LOLU_ASSERT_ALWAYS(a_lcount_range,
    (lcount_r != '0) && (lcount_r <= LCW'(MAX_LINES)), "line count out of range")
  `LOLU_ASSERT_IMPL(a_search_bounds, state_r != ST_IDLE,
    (lo_r <= hi_r) && (hi_r <= lcount_r), "search window outside table")
  `LOLU_ASSERT_IMPL(a_start_not_above_pos, state_r != ST_IDLE,
    start_r <= pos_r, "line start above query offset")
  `LOLU_ASSERT_IMPL(a_overflow_only_when_full, ovf_r,
    lcount_r == LCW'(MAX_LINES), "overflow flagged with table not full")

endmodule

/* tb/sv/line_offset_index_lookup_unit_tb.sv */
// Self-checking testbench for the line offset lookup unit.
// Depends on lolu_pkg and line_offset_index_lookup_unit; carries its own line-start predictor.
module line_offset_index_lookup_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lolu_pkg::*;

  localparam int MAX_LINES   = 4096;
  localparam int OFFSET_BITS = 20;
  localparam int IN_W        = 32;
  localparam int OUT_W       = 56;
  localparam logic [OFFSET_BITS-1:0] OFFSET_MASK = '1;
  // selector value the block has no meaning for
  localparam logic [TUSER_W-1:0] REQ_UNUSED = 2'd3;
  localparam int IDLE_PCT    = 26;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_BEATS = 500;
  // stretch of the random traffic run with no idling on either side
  localparam int BUSY_FIRST  = 200;
  localparam int BUSY_LAST   = 300;

  // one location answer, line number in the lowest bits
  typedef struct packed {
    logic                   overflow_seen;
    logic [OFFSET_BITS-1:0] clamped;
    logic [20:0]            column_no;
    logic [12:0]            line_no;
  } loc_result_t;

  // one row of the directed stimulus
  typedef struct packed {
    logic [TUSER_W-1:0]     kind;
    logic [7:0]             data_byte;
    logic [OFFSET_BITS-1:0] query_off;
    logic                   typed;
    loc_result_t            res;
  } dir_row_t;

  localparam loc_result_t NO_RES   = '0;
  localparam loc_result_t AT_START = '{1'b0, 20'd0, 21'd1, 13'd1};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata = '0;   // text_byte, query_offset
  logic [TUSER_W-1:0]  in_tuser = REQ_CLEAR;  // req_type
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;  // line_number, column_number, clamped_offset,
                                   // table_overflow

  // predictor state
  logic [OFFSET_BITS-1:0] line_starts [MAX_LINES];
  int unsigned            line_total = 1;
  logic [OFFSET_BITS-1:0] text_len = '0;
  logic                   overflowed = 1'b0;
  loc_result_t            pending_locations [$];

  int  mismatch_count = 0;
  int  results_checked = 0;
  int  beats_sent = 0;
  int  quiet_cycles = 0;
  int  hold_left = 0;
  bit  send_idle_en = 1'b1;
  bit  recv_idle_en = 1'b1;
  bit  hold_armed = 1'b0;
  bit  hold_done = 1'b0;

  dir_row_t dir_rows [22] = '{
    '{REQ_QUERY,  8'h00, 20'h00000, 1'b1, AT_START},
    '{REQ_QUERY,  8'h00, 20'hFFFFF, 1'b1, AT_START},  // past end of empty text
    '{REQ_UNUSED, 8'hA5, 20'h5A5A5, 1'b0, NO_RES},
    '{REQ_BYTE,   8'h61, 20'h00000, 1'b0, NO_RES},
    '{REQ_BYTE,   8'h0A, 20'h00000, 1'b0, NO_RES},
    '{REQ_BYTE,   8'h00, 20'hFFFFF, 1'b0, NO_RES},
    '{REQ_BYTE,   8'hFF, 20'h00000, 1'b0, NO_RES},
    '{REQ_BYTE,   8'h0A, 20'h00000, 1'b0, NO_RES},
    '{REQ_QUERY,  8'h00, 20'h00000, 1'b0, NO_RES},
    '{REQ_QUERY,  8'hFF, 20'h00001, 1'b0, NO_RES},
    '{REQ_QUERY,  8'h00, 20'h00002, 1'b0, NO_RES},
    '{REQ_QUERY,  8'h00, 20'h00005, 1'b0, NO_RES},
    '{REQ_QUERY,  8'h00, 20'hFFFFF, 1'b0, NO_RES},
    '{REQ_UNUSED, 8'h0A, 20'hFFFFF, 1'b0, NO_RES},  // newline on the unused selector
    '{REQ_QUERY,  8'h00, 20'h00004, 1'b0, NO_RES},
    '{REQ_CLEAR,  8'hFF, 20'hFFFFF, 1'b0, NO_RES},
    '{REQ_QUERY,  8'h00, 20'hFFFFF, 1'b1, AT_START},
    '{REQ_BYTE,   8'h0A, 20'h00000, 1'b0, NO_RES},
    '{REQ_QUERY,  8'h00, 20'h00000, 1'b1, AT_START},
    '{REQ_QUERY,  8'h00, 20'h00001, 1'b1, '{1'b0, 20'd1, 21'd1, 13'd2}},
    '{REQ_CLEAR,  8'h00, 20'h00000, 1'b0, NO_RES},
    '{REQ_QUERY,  8'h00, 20'h00000, 1'b1, AT_START}
  };

  line_offset_index_lookup_unit #(
    .MAX_LINES  (MAX_LINES),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // binary search over the recorded line starts
  function automatic loc_result_t locate_offset(input logic [OFFSET_BITS-1:0] off);
    logic [OFFSET_BITS-1:0] pos;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    loc_result_t r;
    pos = (off > text_len) ? text_len : off;
    lo = 0;
    hi = line_total;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (line_starts[mid] <= pos) lo = mid + 1;
      else hi = mid;
    end
    if (lo == 0) lo = 1;
    r.line_no       = 13'(lo);
    r.column_no     = {1'b0, pos} - {1'b0, line_starts[lo-1]} + 21'd1;
    r.clamped       = pos;
    r.overflow_seen = overflowed;
    return r;
  endfunction

  // update the line table for an accepted beat; queue the answer of a query
  task automatic track_beat(input logic [TUSER_W-1:0] kind, input logic [7:0] b,
                            input logic [OFFSET_BITS-1:0] off, input logic typed,
                            input loc_result_t typed_res);
    case (kind)
      REQ_CLEAR: begin
        line_starts[0] = '0;
        line_total = 1;
        text_len = '0;
        overflowed = 1'b0;
      end
      REQ_BYTE: begin
        // bytes past the longest text are dropped whole
        if (text_len != OFFSET_MASK) begin
          text_len = text_len + 1'b1;
          if (b == NEWLINE_BYTE) begin
            if (line_total < MAX_LINES) begin
              line_starts[line_total] = text_len;
              line_total++;
            end else begin
              overflowed = 1'b1;
            end
          end
        end
      end
      REQ_QUERY: pending_locations.insert(pending_locations.size(),
                                          typed ? typed_res : locate_offset(off));
      default: ;
    endcase
  endtask

  // offer one beat, at times with a random gap in front of it
  task automatic send_beat(input logic [TUSER_W-1:0] kind, input logic [7:0] b,
                           input logic [OFFSET_BITS-1:0] off, input logic typed = 1'b0,
                           input loc_result_t typed_res = '0);
    if (send_idle_en && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {{(IN_W - 8 - OFFSET_BITS){1'b0}}, off, b};
    do @(posedge clk); while (!in_tready);
    beats_sent++;
    track_beat(kind, b, off, typed, typed_res);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    $display("ERROR %s: expected %0d, got %0d (result %0d)", what, exp_v, got_v,
             results_checked);
    mismatch_count++;
  endtask

  // random query offset, biased to line starts and to offsets within or just past the text
  function automatic logic [OFFSET_BITS-1:0] pick_offset();
    int unsigned r;
    int unsigned hi;
    logic [OFFSET_BITS-1:0] s;
    r = $urandom_range(99);
    if (r < 20) begin
      s = line_starts[$urandom_range(line_total - 1, 0)];
      return ($urandom_range(1) != 0 && s != 0) ? s - 1'b1 : s;
    end
    if (r < 80) begin
      hi = int'(text_len) + 3;
      if (hi > int'(OFFSET_MASK)) hi = OFFSET_MASK;
      return OFFSET_BITS'($urandom_range(hi, 0));
    end
    return OFFSET_BITS'($urandom_range(OFFSET_MASK, 0));
  endfunction

  // result side: check accepted beats, random back-pressure, one long hold-off
  always @(posedge clk) begin
    loc_result_t got;
    loc_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(loc_result_t)-1:0];
        if (pending_locations.size() == 0) begin
          report_mismatch("unexpected result beat", 0, 1);
        end else begin
          want = pending_locations.pop_front();
          if (got.line_no != want.line_no)
            report_mismatch("line_number", want.line_no, got.line_no);
          if (got.column_no != want.column_no)
            report_mismatch("column_number", want.column_no, got.column_no);
          if (got.clamped != want.clamped)
            report_mismatch("clamped_offset", want.clamped, got.clamped);
          if (got.overflow_seen != want.overflow_seen)
            report_mismatch("table_overflow", want.overflow_seen, got.overflow_seen);
        end
        results_checked++;
      end
      if (hold_armed && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !recv_idle_en || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d idle cycles", quiet_cycles);
        $display("line_offset_index_lookup_unit: mismatch");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int unsigned r;
    // the first line always starts at offset zero
    line_starts[0] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    foreach (dir_rows[i])
      send_beat(dir_rows[i].kind, dir_rows[i].data_byte, dir_rows[i].query_off,
                dir_rows[i].typed, dir_rows[i].res);

    // random traffic, mostly short multi-line texts
    send_beat(REQ_CLEAR, 8'h00, '0);
    hold_armed = 1'b1;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      // one stretch runs flat out on both sides
      if (i == BUSY_FIRST) begin
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
      end
      if (i == BUSY_LAST) begin
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 2)
        send_beat(REQ_CLEAR, 8'($urandom_range(255)), OFFSET_BITS'($urandom));
      else if (r < 4)
        send_beat(REQ_UNUSED, 8'($urandom_range(255)), OFFSET_BITS'($urandom));
      else if (r < 62)
        send_beat(REQ_BYTE, ($urandom_range(99) < 30) ? NEWLINE_BYTE
                            : 8'($urandom_range(255)), OFFSET_BITS'($urandom));
      else
        send_beat(REQ_QUERY, 8'($urandom_range(255)), pick_offset());
    end
    in_tvalid <= 1'b0;

    // drain
    while (pending_locations.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d input beats and %0d location results: directed cases,",
             beats_sent, results_checked);
    $display("random multi-line texts, a long output hold-off and a stretch at full rate");
    if (mismatch_count == 0) begin
      $display("line_offset_index_lookup_unit: match");
    end else begin
      $display("line_offset_index_lookup_unit: mismatch");
    end
    $finish;
  end

endmodule
